// File: hw/rtl/mma_pkg.sv
package mma_pkg;

   localparam int MAX_DIM_DEFAULT = 64;

   localparam int OP_W   = 3;
   localparam int IDX_W  = 6;
   localparam int ELEM_W = 16;
   localparam int ACC_W  = 48;
   localparam int CSR_W  = 7;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int D_SHIFT = 8;

   localparam logic [OP_W-1:0] OP_LOAD_A   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B   = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_D   = 3'd2;
   localparam logic [OP_W-1:0] OP_MULTIPLY = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_D   = 3'd4;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic [CSR_W-1:0] DIM_RESET = 7'd64;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [IDX_W-1:0]         row_index;
      logic [IDX_W-1:0]         col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic signed [ACC_W-1:0] acc_value;
      logic                    saturated;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_d;
      logic read_d;
      logic mac_start;
      logic mac_valid;
      logic mac_first;
      logic mac_last;
      logic done;
   } cmd_type;

endpackage

// File: hw/rtl/matrix_multiply_accumulate.sv
// Channel    Ports                                        Direction
// request    start, busy, req_payload                     in (busy out)
// response   rsp_strobe, rsp_payload                      out
// config     csr_write_en, csr_index, csr_data            in
//
// A load writes its memory when taken; a read answers on rsp_strobe the cycle after it is taken.
// A multiply keeps busy high through R*R*C inner-product steps (R, C = clamped rows/cols in use):
// one inner-product step per cycle through the single read port of each matrix
// memory, plus a three-stage read/multiply/accumulate drain. Done strobes next cycle.
// Reset is synchronous; the matrix memories hold no reset value and need no clear.
// Responses cannot be held off: rsp_strobe is high for exactly one cycle each.
module matrix_multiply_accumulate #(
   parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT,
   localparam int IW = $clog2(MAX_DIM)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mma_pkg::req_type            req_payload,
   output logic                        rsp_strobe,
   output mma_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [mma_pkg::CSR_W-1:0]   csr_data
);

   mma_pkg::cmd_type cmd;
   logic [IW-1:0]    cnt_i, cnt_k, cnt_j;

   mma_controller #(
      .MAX_DIM(MAX_DIM)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_payload.operation),
      .busy          (busy),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .cnt_i         (cnt_i),
      .cnt_k         (cnt_k),
      .cnt_j         (cnt_j)
   );

   mma_datapath #(
      .MAX_DIM(MAX_DIM)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cnt_i       (cnt_i),
      .cnt_k       (cnt_k),
      .cnt_j       (cnt_j),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/mma_controller.sv
module mma_controller #(
   parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT,
   localparam int IW = $clog2(MAX_DIM),
   localparam int DW = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mma_pkg::OP_W-1:0]     req_operation,
   output logic                         busy,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [mma_pkg::CSR_W-1:0]    csr_data,
   output mma_pkg::cmd_type             cmd,
   output logic [IW-1:0]                cnt_i,
   output logic [IW-1:0]                cnt_k,
   output logic [IW-1:0]                cnt_j
);

   localparam int CW = (DW > mma_pkg::CSR_W) ? DW : mma_pkg::CSR_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [mma_pkg::CSR_W-1:0] rows_ff, rows_in;
   logic [mma_pkg::CSR_W-1:0] cols_ff, cols_in;
   logic [IW-1:0] i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [1:0]    drain_ff, drain_in;

   logic [CW-1:0] rows_ext, cols_ext;
   logic [DW-1:0] rdim, cdim, rlast, clast;
   logic          accept, dims_zero, k_last, j_last, i_last;

   always_comb begin
      rows_ext = CW'(rows_ff);
      cols_ext = CW'(cols_ff);
      rdim = (rows_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_ext);
      cdim = (cols_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_ext);
      rlast = rdim - DW'(1);
      clast = cdim - DW'(1);
      dims_zero = (rdim == '0) || (cdim == '0);
      k_last = (DW'(k_ff) == rlast);
      j_last = (DW'(j_ff) == clast);
      i_last = (DW'(i_ff) == rlast);
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cnt_i  = i_ff;
   assign cnt_k  = k_ff;
   assign cnt_j  = j_ff;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mma_pkg::CSR_ROWS: rows_in = csr_data;
            mma_pkg::CSR_COLS: cols_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      drain_in = drain_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  mma_pkg::OP_LOAD_A: cmd.load_a = 1'b1;
                  mma_pkg::OP_LOAD_B: cmd.load_b = 1'b1;
                  mma_pkg::OP_LOAD_D: cmd.load_d = 1'b1;
                  mma_pkg::OP_READ_D: cmd.read_d = 1'b1;
                  mma_pkg::OP_MULTIPLY: begin
                     cmd.mac_start = 1'b1;
                     i_in = '0;
                     k_in = '0;
                     j_in = '0;
                     drain_in = '0;
                     state_in = dims_zero ? ST_DRAIN : ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.mac_valid = 1'b1;
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = k_last;
            // k innermost: one output element accumulates over consecutive cycles
            if (!k_last) begin
               k_in = k_ff + IW'(1);
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in = j_ff + IW'(1);
               end else begin
                  j_in = '0;
                  if (!i_last) begin
                     i_in = i_ff + IW'(1);
                  end else begin
                     drain_in = '0;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // drain states: read data, product, accumulate; write-back lands in the last one
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= mma_pkg::DIM_RESET;
         cols_ff  <= mma_pkg::DIM_RESET;
         i_ff     <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         drain_ff <= drain_in;
      end
   end

endmodule

// File: hw/rtl/mma_datapath.sv
module mma_datapath #(
   parameter int MAX_DIM = mma_pkg::MAX_DIM_DEFAULT,
   localparam int IW = $clog2(MAX_DIM)
) (
   input  logic              clock,
   input  logic              reset,
   input  mma_pkg::cmd_type  cmd,
   input  logic [IW-1:0]     cnt_i,
   input  logic [IW-1:0]     cnt_k,
   input  logic [IW-1:0]     cnt_j,
   input  mma_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output mma_pkg::rsp_type  rsp_payload
);

   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int ACC_W = mma_pkg::ACC_W;
   localparam int EW    = mma_pkg::ELEM_W;
   localparam int PW    = mma_pkg::PROD_W;

   logic signed [EW-1:0]    a_mem [DEPTH];
   logic signed [EW-1:0]    b_mem [DEPTH];
   logic signed [ACC_W-1:0] d_mem [DEPTH];

   logic signed [EW-1:0]    a_rd_ff, b_rd_ff;
   logic signed [ACC_W-1:0] d_rd_ff;

   logic          s1_valid_ff, s1_first_ff, s1_last_ff;
   logic          s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [AW-1:0] s1_addr_ff, s2_addr_ff, wb_addr_ff;
   logic          wb_ff;

   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] base_ff, acc_ff, acc_in;
   logic signed [ACC_W:0]   sum;
   logic                    ovf;
   logic                    sat_ff, sat_in;

   logic                    rsp_valid_ff, rsp_kind_ff, rd_ok_ff;

   logic                    in_range;
   logic [AW-1:0]           req_addr, a_addr, b_addr, d_addr;
   logic signed [ACC_W-1:0] d_load_value;

   always_comb begin
      in_range = (32'(req_payload.row_index) < MAX_DIM) &&
                 (32'(req_payload.col_index) < MAX_DIM);
      req_addr = {IW'(req_payload.row_index), IW'(req_payload.col_index)};
      a_addr   = {cnt_i, cnt_k};
      b_addr   = {cnt_k, cnt_j};
      d_addr   = {cnt_i, cnt_j};
      d_load_value = {{(ACC_W - EW - mma_pkg::D_SHIFT){req_payload.element_value[EW-1]}},
                      req_payload.element_value, {mma_pkg::D_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_a && in_range) begin
         a_mem[req_addr] <= req_payload.element_value;
      end
      if (cmd.mac_valid) begin
         a_rd_ff <= a_mem[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b && in_range) begin
         b_mem[req_addr] <= req_payload.element_value;
      end
      if (cmd.mac_valid) begin
         b_rd_ff <= b_mem[b_addr];
      end
   end

   // single write port shared by loads and multiply write-back (never together)
   always_ff @(posedge clock) begin
      if (cmd.load_d && in_range) begin
         d_mem[req_addr] <= d_load_value;
      end else if (wb_ff) begin
         d_mem[wb_addr_ff] <= acc_ff;
      end
      if (cmd.read_d) begin
         d_rd_ff <= d_mem[req_addr];
      end else if (cmd.mac_valid && cmd.mac_first) begin
         d_rd_ff <= d_mem[d_addr];
      end
   end

   assign prod_in = a_rd_ff * b_rd_ff;

   always_comb begin
      sum = (s2_first_ff ? (ACC_W+1)'(base_ff) : (ACC_W+1)'(acc_ff)) +
            (ACC_W+1)'(prod_ff);
      ovf = (sum[ACC_W] != sum[ACC_W-1]);
      if (!ovf) begin
         acc_in = sum[ACC_W-1:0];
      end else if (sum[ACC_W]) begin
         acc_in = mma_pkg::ACC_MIN;
      end else begin
         acc_in = mma_pkg::ACC_MAX;
      end
      sat_in = sat_ff;
      if (cmd.mac_start) begin
         sat_in = 1'b0;
      end else if (s2_valid_ff && ovf) begin
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (s1_valid_ff && s1_first_ff) begin
         base_ff <= d_rd_ff;
      end
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      s1_addr_ff <= d_addr;
      s2_addr_ff <= s1_addr_ff;
      wb_addr_ff <= s2_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_first_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_first_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         wb_ff        <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= mma_pkg::KIND_DONE;
         rd_ok_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.mac_valid;
         s1_first_ff  <= cmd.mac_first;
         s1_last_ff   <= cmd.mac_last;
         s2_valid_ff  <= s1_valid_ff;
         s2_first_ff  <= s1_first_ff;
         s2_last_ff   <= s1_last_ff;
         wb_ff        <= s2_valid_ff && s2_last_ff;
         sat_ff       <= sat_in;
         rsp_valid_ff <= cmd.read_d || cmd.done;
         if (cmd.read_d) begin
            rsp_kind_ff <= mma_pkg::KIND_READ;
            rd_ok_ff    <= in_range;
         end else if (cmd.done) begin
            rsp_kind_ff <= mma_pkg::KIND_DONE;
            rd_ok_ff    <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_strobe = rsp_valid_ff;
      rsp_payload.result_kind = rsp_kind_ff;
      rsp_payload.acc_value   = rd_ok_ff ? d_rd_ff : '0;
      rsp_payload.saturated   = sat_ff;
   end

endmodule

// File: test/testbench.sv
module testbench;
   import mma_pkg::*;

   localparam int DIM = MAX_DIM_DEFAULT;
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_READ_D + 3'd1;
   localparam logic [OP_W-1:0] OP_LAST_CODE = {OP_W{1'b1}};
   localparam int SETTLE = 4;
   localparam int STALL_LIMIT = 2000;
   // side of the square corner that every store has written
   localparam int FILL = 4;

   typedef struct {
      req_type     req;
      int unsigned idle_before;
      bit          after_drain;
   } paced_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic csr_index = CSR_ROWS;
   logic [CSR_W-1:0] csr_data = '0;

   matrix_multiply_accumulate dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the unit
   logic signed [ELEM_W-1:0] left_elems [DIM*DIM];
   logic signed [ELEM_W-1:0] right_elems [DIM*DIM];
   logic signed [ACC_W-1:0]  accum_elems [DIM*DIM];
   logic                     sat_sticky = 1'b0;
   logic [CSR_W-1:0]         rows_cfg = DIM_RESET;
   logic [CSR_W-1:0]         cols_cfg = DIM_RESET;

   rsp_type           answers_due [$];
   paced_request_type request_backlog [$];
   logic              results_outstanding = 1'b0;
   bit                failed = 1'b0;
   int unsigned       idle_count = 0;
   int unsigned       stall_cycles = 0;

   int burst_left = 0;
   int burst_cap = 20;
   int gap_cap = 12;
   bit drain_next = 1'b0;

   function automatic void mac_pass();
      int unsigned r, c, i, k, j;
      longint sum;
      r = (rows_cfg > DIM) ? DIM : rows_cfg;
      c = (cols_cfg > DIM) ? DIM : cols_cfg;
      sat_sticky = 1'b0;
      // i, k, j order matters once the clamp kicks in
      for (i = 0; i < r; i++)
         for (k = 0; k < r; k++)
            for (j = 0; j < c; j++) begin
               sum = longint'(accum_elems[i*DIM+j]) +
                     longint'(left_elems[i*DIM+k]) * longint'(right_elems[k*DIM+j]);
               if (sum > longint'(ACC_MAX)) begin
                  sum = longint'(ACC_MAX);
                  sat_sticky = 1'b1;
               end else if (sum < longint'(ACC_MIN)) begin
                  sum = longint'(ACC_MIN);
                  sat_sticky = 1'b1;
               end
               accum_elems[i*DIM+j] = sum[ACC_W-1:0];
            end
   endfunction

   function automatic void step_matrix_unit(req_type req);
      int at;
      longint scaled;
      rsp_type answer;
      at = int'(req.row_index) * DIM + int'(req.col_index);
      scaled = longint'(req.element_value) <<< D_SHIFT;
      case (req.operation)
         OP_LOAD_A: left_elems[at] = req.element_value;
         OP_LOAD_B: right_elems[at] = req.element_value;
         OP_LOAD_D: accum_elems[at] = scaled[ACC_W-1:0];
         OP_MULTIPLY: begin
            mac_pass();
            answer.result_kind = KIND_DONE;
            answer.acc_value = '0;
            answer.saturated = sat_sticky;
            answers_due.push_back(answer);
         end
         OP_READ_D: begin
            answer.result_kind = KIND_READ;
            answer.acc_value = accum_elems[at];
            answer.saturated = sat_sticky;
            answers_due.push_back(answer);
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // driver: a held request stays up until taken; gaps are counted in free cycles
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_count <= 0;
      end else if (!start || !busy) begin
         if (request_backlog.size() != 0 &&
             idle_count >= request_backlog[0].idle_before &&
             (!request_backlog[0].after_drain || (!start && !results_outstanding))) begin
            req_payload <= request_backlog[0].req;
            request_backlog.pop_front();
            idle_count <= 0;
            start <= 1'b1;
         end else begin
            if (request_backlog.size() != 0)
               idle_count <= idle_count + 1;
            start <= 1'b0;
         end
      end
   end

   // monitor: responses are checked before this edge's request is predicted
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rows_cfg = DIM_RESET;
         cols_cfg = DIM_RESET;
         sat_sticky = 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response with none due: expected nothing, got kind %0d %s %0d",
                        $time, rsp_payload.result_kind, "value", rsp_payload.acc_value);
               failed = 1'b1;
            end else begin
               due = answers_due.pop_front();
               check_field("result_kind", due.result_kind, rsp_payload.result_kind);
               check_field("acc_value", due.acc_value, rsp_payload.acc_value);
               check_field("saturated", due.saturated, rsp_payload.saturated);
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_ROWS)
               rows_cfg = csr_data;
            else
               cols_cfg = csr_data;
         end
         if (start && !busy)
            step_matrix_unit(req_payload);
         results_outstanding <= (answers_due.size() != 0);
         if ((start && !busy) || rsp_strobe)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[matrix_multiply_accumulate] ERROR");
            $finish;
         end
      end
   end

   task automatic send(logic [OP_W-1:0] op, int row, int col, int value);
      paced_request_type item;
      item.req.operation = op;
      item.req.row_index = row[IDX_W-1:0];
      item.req.col_index = col[IDX_W-1:0];
      item.req.element_value = value[ELEM_W-1:0];
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_cap);
         item.idle_before = $urandom_range(1, gap_cap);
      end else begin
         item.idle_before = 0;
      end
      burst_left--;
      item.after_drain = drain_next;
      drain_next = 1'b0;
      request_backlog.push_back(item);
   endtask

   task automatic wait_quiet();
      do
         @(negedge clock);
      while (request_backlog.size() != 0 || start || busy || results_outstanding);
      // loads answer nothing, so let the last one retire
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_dims(int rows, int cols);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_data <= rows[CSR_W-1:0];
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_data <= cols[CSR_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int dir_rows [6];
      int dir_cols [6];
      int rr, cc, pick, row, col, value, rows, cols;
      logic [OP_W-1:0] op;

      dir_rows = '{0, 1, 4, 127, 3, 1};
      dir_cols = '{64, 64, 1, 0, 4, 127};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every multiply and read stays inside the corner and row 0 written here, or on a corner cell loaded below
      for (row = 0; row < FILL; row++)
         for (col = 0; col < FILL; col++) begin
            send(OP_LOAD_A, row, col, $urandom_range(0, 65535));
            send(OP_LOAD_B, row, col, $urandom_range(0, 65535));
            send(OP_LOAD_D, row, col, $urandom_range(0, 65535));
         end
      for (col = FILL; col < DIM; col++) begin
         send(OP_LOAD_B, 0, col, $urandom_range(0, 65535));
         send(OP_LOAD_D, 0, col, $urandom_range(0, 65535));
      end

      // corners and extreme values
      send(OP_LOAD_A, 0, 0, -32768);
      send(OP_LOAD_A, DIM-1, DIM-1, 32767);
      send(OP_LOAD_B, DIM-1, 0, -32768);
      send(OP_LOAD_B, 0, DIM-1, 32767);
      send(OP_LOAD_D, DIM-1, DIM-1, 32767);
      send(OP_LOAD_D, 0, DIM-1, -32768);
      send(OP_LOAD_D, DIM-1, 0, 12345);
      send(OP_READ_D, DIM-1, DIM-1, 0);
      send(OP_READ_D, 0, DIM-1, 0);
      send(OP_READ_D, DIM-1, 0, 0);
      for (pick = OP_FIRST_UNUSED; pick <= OP_LAST_CODE; pick++)
         send(pick[OP_W-1:0], DIM-1, DIM-1, -1);

      // zero, full and oversized dimensions
      for (pick = 0; pick < 6; pick++) begin
         wait_quiet();
         set_dims(dir_rows[pick], dir_cols[pick]);
         rr = (dir_rows[pick] > DIM) ? DIM : dir_rows[pick];
         cc = (dir_cols[pick] > DIM) ? DIM : dir_cols[pick];
         send(OP_MULTIPLY, 0, 0, 0);
         send(OP_READ_D, (rr == 0) ? 0 : rr - 1, (cc == 0) ? 0 : cc - 1, 0);
      end

      for (pick = 0; pick < 6; pick++) begin
         wait_quiet();
         case (pick)
            4: begin
               rows = 1;
               cols = $urandom_range(DIM + 1, 2**CSR_W - 1);
            end
            5: begin
               rows = $urandom_range(DIM + 1, 2**CSR_W - 1);
               cols = 0;
            end
            default: begin
               rows = $urandom_range(0, FILL);
               cols = $urandom_range(0, FILL);
            end
         endcase
         set_dims(rows, cols);
         for (rr = 0; rr < 42; rr++) begin
            cc = $urandom_range(0, 99);
            if (cc < 22)
               op = OP_LOAD_A;
            else if (cc < 44)
               op = OP_LOAD_B;
            else if (cc < 60)
               op = OP_LOAD_D;
            else if (cc < 70)
               op = OP_MULTIPLY;
            else if (cc < 92)
               op = OP_READ_D;
            else
               op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
            row = $urandom_range(0, FILL-1);
            col = $urandom_range(0, FILL-1);
            if (op == OP_READ_D && $urandom_range(0, 3) == 0) begin
               // row 0 is written across its full width
               row = 0;
               col = $urandom_range(0, DIM-1);
            end else if (op != OP_MULTIPLY && op != OP_READ_D &&
                         $urandom_range(0, 3) == 0) begin
               row = $urandom_range(0, DIM-1);
               col = $urandom_range(0, DIM-1);
            end
            if ($urandom_range(0, 3) == 0)
               value = $urandom_range(0, 1) ? -32768 : 32767;
            else
               value = $urandom_range(0, 65535);
            if (rr % 21 == 20)
               drain_next = 1'b1;
            send(op, row, col, value);
         end
      end

      wait_quiet();
      repeat (16) @(negedge clock);
      if (!failed)
         $display("[matrix_multiply_accumulate] OK");
      else
         $display("[matrix_multiply_accumulate] ERROR");
      $finish;
   end

endmodule
